// ----- hw/rtl/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the binary cyclic code encoder
// Word widths, register map, reset values, the beat and config structs.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // working width of the division chain and of the polynomial register
    localparam int DATA_W        = 64;
    // width of message, codeword and parity ports
    localparam int MSG_W         = 63;
    // width of the length registers
    localparam int LEN_W         = 6;
    // default kept width of the carry-free product
    localparam int DEF_WORD_BITS = 64;

    // register map: 64-bit registers on an 8-byte stride
    localparam int NUM_REGS = 4;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int ADDR_W   = IDX_W + 3;

    typedef enum logic [IDX_W-1:0] {
        REG_GEN      = 2'd0,
        REG_CODE_LEN = 2'd1,
        REG_MSG_LEN  = 2'd2,
        REG_MODE     = 2'd3
    } t_reg_idx;

    localparam logic [DATA_W-1:0] RST_GEN      = 64'd11;
    localparam logic [LEN_W-1:0]  RST_CODE_LEN = 6'd7;
    localparam logic [LEN_W-1:0]  RST_MSG_LEN  = 6'd4;
    localparam logic              RST_MODE     = 1'b1;

    // one beat moving down the cell chain
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] w;    // working word: product, then remainder
        logic [DATA_W-1:0] aux;  // message bits, or the shifted message
    } t_beat;

    // configuration plus the divisor prepared for the division cells
    typedef struct packed {
        logic [DATA_W-1:0] gen;
        logic [LEN_W-1:0]  n;
        logic [LEN_W-1:0]  k;
        logic              sys;
        logic [DATA_W-1:0] div_norm;   // divisor shifted so its top bit is bit 63
        logic [LEN_W-1:0]  div_shift;  // 63 minus divisor degree
        logic              div_zero;   // divisor is all zero
    } t_cfg;

    // mask of the low 'width' bits, width 0..64
    function automatic logic [DATA_W-1:0] low_mask(input logic [LEN_W:0] width);
        logic [DATA_W-1:0] m;
        if (width >= (LEN_W+1)'(DATA_W)) begin
            m = '1;
        end else begin
            m = (DATA_W'(1) << width) - DATA_W'(1);
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/bcc_regs.sv -----
// ----------------------------------------------------------------------------
// bcc_regs: configuration registers
// APB register file and the registered divisor normalization for the chain.
// ----------------------------------------------------------------------------
module bcc_regs import bcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    // position of the highest set bit (zero for an all-zero word)
    function automatic logic [LEN_W-1:0] top_bit(input logic [DATA_W-1:0] p);
        logic [LEN_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (p[i]) begin
                pos = LEN_W'(i);
            end
        end
        return pos;
    endfunction

    logic [DATA_W-1:0] r_gen;
    logic [LEN_W-1:0]  r_code_len;
    logic [LEN_W-1:0]  r_msg_len;
    logic              r_sys;

    logic              w_wr;
    t_reg_idx          w_idx;
    logic [DATA_W-1:0] w_div;

    logic [DATA_W-1:0] r_div_src;
    logic [LEN_W-1:0]  r_div_shift;
    logic              r_div_zero;
    logic [DATA_W-1:0] r_div_norm;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen      <= RST_GEN;
            r_code_len <= RST_CODE_LEN;
            r_msg_len  <= RST_MSG_LEN;
            r_sys      <= RST_MODE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GEN:      r_gen      <= pwdata;
                REG_CODE_LEN: r_code_len <= pwdata[LEN_W-1:0];
                REG_MSG_LEN:  r_msg_len  <= pwdata[LEN_W-1:0];
                REG_MODE:     r_sys      <= pwdata[0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_GEN:      prdata = r_gen;
            REG_CODE_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, r_code_len};
            REG_MSG_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, r_msg_len};
            REG_MODE:     prdata = {{(DATA_W-1){1'b0}}, r_sys};
        endcase
    end

    // divisor: generator in systematic mode, x^n + 1 otherwise
    assign w_div = r_sys ? r_gen
                         : ((DATA_W'(1) << r_code_len) | DATA_W'(1));

    // two-step normalization: find degree, then left-align
    always_ff @(posedge i_clk) begin
        r_div_src   <= w_div;
        r_div_shift <= LEN_W'(DATA_W-1) - top_bit(w_div);
        r_div_zero  <= (w_div == '0);
        r_div_norm  <= r_div_src << r_div_shift;
    end

    assign o_cfg.gen       = r_gen;
    assign o_cfg.n         = r_code_len;
    assign o_cfg.k         = r_msg_len;
    assign o_cfg.sys       = r_sys;
    assign o_cfg.div_norm  = r_div_norm;
    assign o_cfg.div_shift = r_div_shift;
    assign o_cfg.div_zero  = r_div_zero;

endmodule

// ----- hw/rtl/bcc_mul_cell.sv -----
// ----------------------------------------------------------------------------
// bcc_mul_cell: one step of the carry-free multiply
// Adds the generator shifted by this cell's bit position when that message
// bit is set (non-systematic mode only); passes the beat on through registers.
// ----------------------------------------------------------------------------
module bcc_mul_cell import bcc_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int IDX       = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_beat i_beat,
    output t_beat o_beat
);

    // product bits kept
    localparam logic [DATA_W-1:0] PROD_MASK =
        (WORD_BITS >= DATA_W) ? {DATA_W{1'b1}}
                              : ((DATA_W'(1) << WORD_BITS) - DATA_W'(1));

    logic              r_valid;
    logic [DATA_W-1:0] r_w;
    logic [DATA_W-1:0] r_aux;
    logic [DATA_W-1:0] w_pp;

    // partial product, idle in systematic mode
    assign w_pp = (!i_cfg.sys && i_beat.aux[IDX]) ? ((i_cfg.gen << IDX) & PROD_MASK)
                                                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= i_beat.w ^ w_pp;
        r_aux <= i_beat.aux;
    end

    assign o_beat.valid = r_valid;
    assign o_beat.w     = r_w;
    assign o_beat.aux   = r_aux;

endmodule

// ----- hw/rtl/bcc_div_cell.sv -----
// ----------------------------------------------------------------------------
// bcc_div_cell: one step of the GF(2) long division
// Clears working bit 63-IDX by XORing in the aligned divisor when set.
// ----------------------------------------------------------------------------
module bcc_div_cell import bcc_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_beat i_beat,
    output t_beat o_beat
);

    localparam logic [LEN_W-1:0] STEP = LEN_W'(IDX);
    localparam int               BIT  = DATA_W - 1 - IDX;

    logic              r_valid;
    logic [DATA_W-1:0] r_w;
    logic [DATA_W-1:0] r_aux;
    logic              w_hit;

    // step only while the bit is at or above the divisor degree
    assign w_hit = !i_cfg.div_zero && (STEP <= i_cfg.div_shift) && i_beat.w[BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= w_hit ? (i_beat.w ^ (i_cfg.div_norm >> IDX)) : i_beat.w;
        r_aux <= i_beat.aux;
    end

    assign o_beat.valid = r_valid;
    assign o_beat.w     = r_w;
    assign o_beat.aux   = r_aux;

endmodule

// ----- hw/rtl/binary_cyclic_code_encoder.sv -----
// o_valid is high for one cycle per result word, from the output register after the last
//   division cell; the receiver cannot stall it.
// Throughput: one word per cycle; busy is low whenever out of reset.
// The pipeline is the chain of WORD_BITS multiply cells and 64 division cells,
//   one bit step each, every cell registered, then the output register.
// Reset (synchronous, active low) clears the beat valids and loads register defaults.
// ----------------------------------------------------------------------------
// binary_cyclic_code_encoder: pipelined binary cyclic code encoder
// Systematic (shift and remainder) or non-systematic (multiply mod x^n+1)
// encoding through a chain of multiply cells and long-division cells.
// ----------------------------------------------------------------------------
module binary_cyclic_code_encoder import bcc_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MSG_W-1:0]  i_message,
    output logic              o_valid,
    output logic [MSG_W-1:0]  o_codeword,
    output logic [MSG_W-1:0]  o_parity,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int NUM_MUL   = WORD_BITS;
    localparam int NUM_DIV   = DATA_W;
    localparam int NUM_CELLS = NUM_MUL + NUM_DIV;
    localparam int LATENCY   = NUM_CELLS + 1;

    t_cfg              w_cfg;
    t_beat             w_chain [NUM_CELLS+1];
    t_beat             w_last;

    logic [LEN_W-1:0]  w_k_eff;
    logic [LEN_W-1:0]  w_pad;
    logic [DATA_W-1:0] w_kmask;
    logic [MSG_W-1:0]  w_msg;
    logic [DATA_W-1:0] w_shifted;
    logic [DATA_W-1:0] w_nmask;
    logic [DATA_W-1:0] w_par;
    logic [DATA_W-1:0] w_cw;

    logic              r_valid;
    logic [MSG_W-1:0]  r_codeword;
    logic [MSG_W-1:0]  r_parity;

    // configuration port
    bcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign busy = !i_rst_n;

    // entry: clip k to n, mask the message, shift up by n-k
    assign w_k_eff   = (w_cfg.k > w_cfg.n) ? w_cfg.n : w_cfg.k;
    assign w_pad     = w_cfg.n - w_k_eff;
    assign w_kmask   = low_mask({1'b0, w_k_eff});
    assign w_msg     = i_message & w_kmask[MSG_W-1:0];
    assign w_shifted = {1'b0, w_msg} << w_pad;

    assign w_chain[0].valid = start && !busy;
    assign w_chain[0].w     = w_cfg.sys ? w_shifted : '0;
    assign w_chain[0].aux   = w_cfg.sys ? w_shifted : {1'b0, w_msg};

    // multiply cells
    for (genvar gi = 0; gi < NUM_MUL; gi++) begin : g_mul
        bcc_mul_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX       (gi)
        ) u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_cfg),
            .i_beat  (w_chain[gi]),
            .o_beat  (w_chain[gi+1])
        );
    end

    // division cells
    for (genvar di = 0; di < NUM_DIV; di++) begin : g_div
        bcc_div_cell #(
            .IDX (di)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_cfg),
            .i_beat  (w_chain[NUM_MUL+di]),
            .o_beat  (w_chain[NUM_MUL+di+1])
        );
    end

    // result assembly
    assign w_last  = w_chain[NUM_CELLS];
    assign w_nmask = low_mask({1'b0, w_cfg.n});
    assign w_par   = (w_cfg.sys && !w_cfg.div_zero) ? w_last.w : '0;
    assign w_cw    = (w_cfg.sys ? (w_last.aux ^ w_par) : w_last.w) & w_nmask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_codeword <= w_cw[MSG_W-1:0];
        r_parity   <= w_par[MSG_W-1:0];
    end

    assign o_valid    = r_valid;
    assign o_codeword = r_codeword;
    assign o_parity   = r_parity;

`ifndef SYNTH
    // every accepted word comes out after the fixed chain latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted word did not come out on time");

    // no result without a word accepted one latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching input beat");

    // non-systematic results carry zero parity
    a_nonsys_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(w_cfg.sys)) |-> (o_parity == '0))
        else $error("parity nonzero in non-systematic mode");

    // codeword has nothing at or above bit n
    a_cw_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (({1'b0, o_codeword} & ~$past(w_nmask)) == '0))
        else $error("codeword bits beyond code length");
`endif

endmodule

// ----- tb/bcc_encoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_encoder_checker: in-order scoreboard for the binary cyclic code encoder
// Mirrors the register file from the APB port, predicts codeword and parity
// for every accepted message beat and compares each result beat in order.
// ----------------------------------------------------------------------------
module bcc_encoder_checker import bcc_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [MSG_W-1:0]  i_message,
    input  logic              o_valid,
    input  logic [MSG_W-1:0]  o_codeword,
    input  logic [MSG_W-1:0]  o_parity,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                n_errors,
    output int                n_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] gen;
        logic [LEN_W-1:0]  n;
        logic [LEN_W-1:0]  k;
        logic              sys;
    } t_code_cfg;

    typedef struct packed {
        logic [MSG_W-1:0] codeword;
        logic [MSG_W-1:0] parity;
    } t_code_word;

    t_code_cfg  code_cfg;
    t_code_word codewords_due[$];
    int         fail_cnt = 0;

    // remainder of a modulo d over GF(2); zero divisor gives zero
    function automatic logic [DATA_W-1:0] poly_rem(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] r;
        int                deg;
        r   = a;
        deg = -1;
        for (int i = 0; i < DATA_W; i++) begin
            if (d[i]) deg = i;
        end
        if (deg < 0) return '0;
        for (int i = DATA_W - 1; i >= deg; i--) begin
            if (r[i]) r ^= d << (i - deg);
        end
        return r;
    endfunction

    // carry-free product, kept to WORD_BITS bits
    function automatic logic [DATA_W-1:0] poly_mul(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (b[i]) acc ^= a << i;
        end
        return acc & ((DATA_W'(1) << WORD_BITS) - DATA_W'(1));
    endfunction

    // expected result beat for one message under the given code setting
    function automatic t_code_word encode_message(input t_code_cfg c,
                                                  input logic [MSG_W-1:0] msg);
        t_code_word        res;
        logic [LEN_W-1:0]  k;
        logic [DATA_W-1:0] m, nmask, shifted, rem, cw;
        k     = (c.k > c.n) ? c.n : c.k;
        m     = DATA_W'(msg) & ((DATA_W'(1) << k) - DATA_W'(1));
        nmask = (DATA_W'(1) << c.n) - DATA_W'(1);
        if (c.sys) begin
            shifted = m << (c.n - k);
            rem     = poly_rem(shifted, c.gen);
            cw      = (shifted ^ rem) & nmask;
        end else begin
            rem = '0;
            cw  = poly_rem(poly_mul(m, c.gen), (DATA_W'(1) << c.n) | DATA_W'(1)) & nmask;
        end
        res.codeword = cw[MSG_W-1:0];
        res.parity   = rem[MSG_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_code_word        want;
        t_reg_idx          idx;
        logic [DATA_W-1:0] rd_want;
        if (!i_rst_n) begin
            code_cfg = '{gen: RST_GEN, n: RST_CODE_LEN, k: RST_MSG_LEN, sys: RST_MODE};
            codewords_due.delete();
        end else begin
            // message beat taken: predict with the current setting
            if (start && !busy) codewords_due.push_back(encode_message(code_cfg, i_message));

            // result beat: compare against the oldest prediction
            if (o_valid) begin
                if (codewords_due.size() == 0) begin
                    $error("unexpected result beat: codeword %h parity %h",
                           o_codeword, o_parity);
                    fail_cnt++;
                end else begin
                    want = codewords_due.pop_front();
                    if (o_codeword !== want.codeword) begin
                        $error("codeword: expected %h, got %h", want.codeword, o_codeword);
                        fail_cnt++;
                    end
                    if (o_parity !== want.parity) begin
                        $error("parity: expected %h, got %h", want.parity, o_parity);
                        fail_cnt++;
                    end
                end
            end

            // register access completes in the APB access phase
            if (psel && penable && pready) begin
                idx = t_reg_idx'(paddr[ADDR_W-1:3]);
                if (pwrite) begin
                    case (idx)
                        REG_GEN:      code_cfg.gen = pwdata;
                        REG_CODE_LEN: code_cfg.n   = pwdata[LEN_W-1:0];
                        REG_MSG_LEN:  code_cfg.k   = pwdata[LEN_W-1:0];
                        REG_MODE:     code_cfg.sys = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (idx)
                        REG_GEN:      rd_want = code_cfg.gen;
                        REG_CODE_LEN: rd_want = DATA_W'(code_cfg.n);
                        REG_MSG_LEN:  rd_want = DATA_W'(code_cfg.k);
                        REG_MODE:     rd_want = DATA_W'(code_cfg.sys);
                        default:      rd_want = '0;
                    endcase
                    if (prdata !== rd_want) begin
                        $error("prdata %s: expected %h, got %h", idx.name(), rd_want, prdata);
                        fail_cnt++;
                    end
                end
            end
        end
        n_errors  <= fail_cnt;
        n_pending <= codewords_due.size();
    end

endmodule

// ----- tb/binary_cyclic_code_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_cyclic_code_encoder_tb: top-level testbench for the encoder
// Drives message beats and APB register writes/reads, runs directed corner
// cases then random code settings under varying sender gaps; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module binary_cyclic_code_encoder_tb;
    import bcc_pkg::*;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic [MSG_W-1:0]  i_message = '0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic              busy;
    logic              o_valid;
    logic [MSG_W-1:0]  o_codeword;
    logic [MSG_W-1:0]  o_parity;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                n_errors;
    int                n_pending;
    int                gap_pct = 26;

    always #10 i_clk = ~i_clk;

    binary_cyclic_code_encoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_message  (i_message),
        .o_valid    (o_valid),
        .o_codeword (o_codeword),
        .o_parity   (o_parity),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    bcc_encoder_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_message  (i_message),
        .o_valid    (o_valid),
        .o_codeword (o_codeword),
        .o_parity   (o_parity),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .n_errors   (n_errors),
        .n_pending  (n_pending)
    );

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // one message beat, with random idle cycles ahead of it
    task automatic send_message(input logic [MSG_W-1:0] msg);
        logic taken;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_message <= msg;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // stop sending and wait for every predicted beat to come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        @(posedge i_clk);
    endtask

    // APB transfer: setup phase, access phase until pready, then back to idle
    task automatic reg_access(input logic wr, input t_reg_idx idx,
                              input logic [DATA_W-1:0] val);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // program a code setting while idle; junk in unused bits checks masking
    task automatic set_code(input logic [DATA_W-1:0] gen, input int n, input int k,
                            input logic sys);
        logic [DATA_W-1:0] junk;
        wait_drained();
        junk = $urandom_range(1) ? {$urandom, $urandom} : '0;
        reg_access(1'b1, REG_GEN, gen);
        reg_access(1'b1, REG_CODE_LEN, {junk[DATA_W-1:LEN_W], LEN_W'(n)});
        reg_access(1'b1, REG_MSG_LEN, {~junk[DATA_W-1:LEN_W], LEN_W'(k)});
        reg_access(1'b1, REG_MODE, {junk[DATA_W-1:1], sys});
        for (int i = 0; i < NUM_REGS; i++) reg_access(1'b0, t_reg_idx'(i), '0);
    endtask

    function automatic logic [MSG_W-1:0] rand_message();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return MSG_W'(1) << $urandom_range(MSG_W - 1);
            default: return MSG_W'({$urandom, $urandom});
        endcase
    endfunction

    // random code setting, extremes weighted in
    task automatic rand_code();
        logic [DATA_W-1:0] gen;
        int                n, k, deg;
        deg = $urandom_range(1, DATA_W - 2);
        case ($urandom_range(7))
            0:       gen = '0;
            1:       gen = '1;
            2:       gen = {$urandom, $urandom};
            default: gen = ({$urandom, $urandom} & ((DATA_W'(1) << deg) - 1))
                           | (DATA_W'(1) << deg) | DATA_W'(1);
        endcase
        case ($urandom_range(5))
            0:       n = 63;
            1:       n = $urandom_range(3);
            default: n = $urandom_range(63);
        endcase
        case ($urandom_range(5))
            0:       k = 0;
            1:       k = $urandom_range(n, 63);
            default: k = $urandom_range(n);
        endcase
        set_code(gen, n, k, 1'($urandom_range(1)));
    endtask

    initial begin
        int done, seg;
        int gaps[3];

        gaps = '{26, 84, 0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: (7,4) code with x^3+x+1
        send_message('0);
        send_message('1);
        send_message(63'h5A5A_5A5A_5A5A_5A5B);
        // zero generator, both modes
        set_code('0, 15, 8, 1'b1);
        send_message('1);
        set_code('0, 15, 8, 1'b0);
        send_message('1);
        // message length above code length
        set_code(64'h13, 10, 40, 1'b1);
        send_message('1);
        send_message(rand_message());
        // zero code length, both modes
        set_code(64'h13, 0, 5, 1'b1);
        send_message('1);
        set_code(64'h13, 0, 5, 1'b0);
        send_message('1);
        // generator degree above n-k, remainder overlaps message
        set_code(64'h1_0000_0001, 20, 18, 1'b1);
        send_message('1);
        send_message(rand_message());
        // widest code, all-ones generator
        set_code('1, 63, 63, 1'b1);
        send_message('1);
        send_message('0);
        send_message(63'h1);
        send_message(63'h4000_0000_0000_0000);
        set_code('1, 63, 63, 1'b0);
        send_message('1);
        send_message(63'h4000_0000_0000_0000);
        // empty message, top-bit generator
        set_code(64'h8000_0000_0000_0000, 63, 0, 1'b1);
        send_message('1);
        set_code(64'h8000_0000_0000_0000, 63, 0, 1'b0);
        send_message('1);
        // one-bit code
        set_code(64'h3, 1, 1, 1'b1);
        send_message('1);
        set_code(64'h3, 1, 1, 1'b0);
        send_message('1);

        // random settings, three sender gap profiles
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = gaps[ph];
            done    = 0;
            while (done < 170) begin
                rand_code();
                seg = $urandom_range(8, 40);
                repeat (seg) send_message(rand_message());
                done += seg;
            end
        end

        wait_drained();
        repeat (DEF_WORD_BITS + 64 + 16) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_regs.sv
hw/rtl/bcc_mul_cell.sv
hw/rtl/bcc_div_cell.sv
hw/rtl/binary_cyclic_code_encoder.sv
tb/bcc_encoder_checker.sv
tb/binary_cyclic_code_encoder_tb.sv
